// File: sv/ksld_pkg.sv
// ----------------------------------------------------------------------------
// ksld_pkg
// Shared types and constants for the keyboard serial link device.
// ----------------------------------------------------------------------------
package ksld_pkg;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_RX_LOW     = 3'd1,
		PH_RX_HIGH    = 3'd2,
		PH_WAIT_READY = 3'd3,
		PH_TX_SETUP   = 3'd4,
		PH_TX_LOW     = 3'd5,
		PH_TX_HIGH    = 3'd6,
		PH_UNUSED     = 3'd7
	} phase_t;

	localparam logic [2:0] CFG_RX_LOW    = 3'd0;
	localparam logic [2:0] CFG_RX_SAMPLE = 3'd1;
	localparam logic [2:0] CFG_RX_HIGH   = 3'd2;
	localparam logic [2:0] CFG_TX_SETUP  = 3'd3;
	localparam logic [2:0] CFG_TX_LOW    = 3'd4;
	localparam logic [2:0] CFG_TX_HIGH   = 3'd5;
	localparam logic [2:0] CFG_TIMEOUT   = 3'd6;

	localparam logic [7:0] CMD_INQUIRY = 8'h10;
	localparam logic [7:0] CMD_INSTANT = 8'h14;
	localparam logic [7:0] CMD_MODEL   = 8'h16;
	localparam logic [7:0] CMD_TEST    = 8'h36;
	localparam logic [7:0] ANS_NULL    = 8'h7B;
	localparam logic [7:0] ANS_MODEL   = 8'h0B;
	localparam logic [7:0] ANS_ACK     = 8'h7D;
	localparam logic [7:0] ANS_NAK     = 8'h77;

	localparam logic [7:0] KEY_CAPS    = 8'h39;
	localparam logic [7:0] KEY_KP_STAR = 8'h55;
	localparam logic [7:0] KEY_KP_PLUS = 8'h57;
	localparam logic [6:0] SCAN_SHIFT  = 7'h38;
	localparam logic [6:0] SCAN_EIGHT  = 7'h1C;
	localparam logic [6:0] SCAN_EQUAL  = 7'h18;
	localparam logic [7:0] NO_SCAN     = 8'hFF;

	typedef struct packed {
		logic [2:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] b3;
		logic       caps_toggle;
	} key_push_t;

	function automatic logic [7:0] scan_lookup(input logic [7:0] c);
		logic [7:0] s;
		s = NO_SCAN;
		unique case (c)
			8'h04: s = 8'h00; 8'h05: s = 8'h0B; 8'h06: s = 8'h08; 8'h07: s = 8'h02;
			8'h08: s = 8'h0E; 8'h09: s = 8'h03; 8'h0A: s = 8'h05; 8'h0B: s = 8'h04;
			8'h0C: s = 8'h22; 8'h0D: s = 8'h26; 8'h0E: s = 8'h28; 8'h0F: s = 8'h25;
			8'h10: s = 8'h2E; 8'h11: s = 8'h2D; 8'h12: s = 8'h1F; 8'h13: s = 8'h23;
			8'h14: s = 8'h0C; 8'h15: s = 8'h0F; 8'h16: s = 8'h01; 8'h17: s = 8'h11;
			8'h18: s = 8'h20; 8'h19: s = 8'h09; 8'h1A: s = 8'h0D; 8'h1B: s = 8'h07;
			8'h1C: s = 8'h10; 8'h1D: s = 8'h06; 8'h1E: s = 8'h12; 8'h1F: s = 8'h13;
			8'h20: s = 8'h14; 8'h21: s = 8'h15; 8'h22: s = 8'h17; 8'h23: s = 8'h16;
			8'h24: s = 8'h1A; 8'h25: s = 8'h1C; 8'h26: s = 8'h19; 8'h27: s = 8'h1D;
			8'h28: s = 8'h24; 8'h29: s = 8'h35; 8'h2A: s = 8'h33; 8'h2B: s = 8'h30;
			8'h2C: s = 8'h31; 8'h2D: s = 8'h1B; 8'h2E: s = 8'h18; 8'h2F: s = 8'h21;
			8'h30: s = 8'h1E; 8'h31: s = 8'h2A; 8'h33: s = 8'h29; 8'h34: s = 8'h27;
			8'h35: s = 8'h32; 8'h36: s = 8'h2B; 8'h37: s = 8'h2F; 8'h38: s = 8'h2C;
			8'h39: s = 8'h39; 8'h4F: s = 8'h42; 8'h50: s = 8'h48; 8'h51: s = 8'h4D;
			8'h52: s = 8'h46; 8'h53: s = 8'h47; 8'h54: s = 8'h2C; 8'h55: s = 8'h02;
			8'h56: s = 8'h1B; 8'h57: s = 8'h16; 8'h58: s = 8'h24; 8'h59: s = 8'h12;
			8'h5A: s = 8'h13; 8'h5B: s = 8'h14; 8'h5C: s = 8'h15; 8'h5D: s = 8'h17;
			8'h5E: s = 8'h16; 8'h5F: s = 8'h1A; 8'h60: s = 8'h1C; 8'h61: s = 8'h19;
			8'h62: s = 8'h1D; 8'h63: s = 8'h2F; 8'h67: s = 8'h18; 8'hE0: s = 8'h37;
			8'hE1: s = 8'h38; 8'hE2: s = 8'h3A; 8'hE3: s = 8'h36; 8'hE4: s = 8'h37;
			8'hE5: s = 8'h38; 8'hE6: s = 8'h7C; 8'hE7: s = 8'h7B;
			default: s = NO_SCAN;
		endcase
		return s;
	endfunction

	function automatic logic [7:0] pack_scan(input logic [6:0] s, input logic brk);
		return {brk | s[6], s[5:0], 1'b1};
	endfunction

endpackage

// File: sv/ksld_key_decode.sv
// ----------------------------------------------------------------------------
// ksld_key_decode
// Translates one key event into up to four packed ring bytes.
// ----------------------------------------------------------------------------
module ksld_key_decode (
	input  logic [15:0]         usage_code,
	input  logic                is_release,
	input  logic                is_media,
	input  logic                caps_q,
	output ksld_pkg::key_push_t push
);
	logic [7:0] scan;
	logic [7:0] code8;

	assign code8 = usage_code[7:0];
	assign scan  = ksld_pkg::scan_lookup(code8);

	always_comb begin
		push = '0;
		if (!is_media && usage_code[15:8] == 8'd0) begin
			if (code8 == ksld_pkg::KEY_CAPS) begin
				if (!is_release) begin
					push.cnt         = 3'd1;
					push.caps_toggle = 1'b1;
					push.b0 = ksld_pkg::pack_scan(ksld_pkg::KEY_CAPS[6:0], caps_q);
				end
			end else if (code8 == ksld_pkg::KEY_KP_STAR || code8 == ksld_pkg::KEY_KP_PLUS) begin
				if (!is_release) begin
					push.cnt = 3'd4;
					push.b0 = ksld_pkg::pack_scan(ksld_pkg::SCAN_SHIFT, 1'b0);
					push.b1 = ksld_pkg::pack_scan((code8 == ksld_pkg::KEY_KP_STAR) ?
						ksld_pkg::SCAN_EIGHT : ksld_pkg::SCAN_EQUAL, 1'b0);
					push.b2 = ksld_pkg::pack_scan((code8 == ksld_pkg::KEY_KP_STAR) ?
						ksld_pkg::SCAN_EIGHT : ksld_pkg::SCAN_EQUAL, 1'b1);
					push.b3 = ksld_pkg::pack_scan(ksld_pkg::SCAN_SHIFT, 1'b1);
				end
			end else if (scan != ksld_pkg::NO_SCAN) begin
				push.cnt = 3'd1;
				push.b0  = ksld_pkg::pack_scan(scan[6:0], is_release);
			end
		end
	end
endmodule

// File: sv/keyboard_serial_link_device_top.sv
// ----------------------------------------------------------------------------
// keyboard_serial_link_device_top
// Device side of a clocked keyboard link with a key-event ring.
// ----------------------------------------------------------------------------
// Input requests on s_axis: tuser = req_type (1 = key event, 0 = line tick),
// tdata = clock_line_in, data_line_in, usage_code, is_release, is_media.
// One result request per input on m_axis with drive levels, link phase,
// caps state, ring level, drop flag, command done and answer byte.
// A tick steps from accept through a ring read, then the link update that
// registers its result; the next request is taken the cycle after.
// A key event makes one ring write per packed byte, so a keypad shifted
// sequence uses four writes of the single ring write port; a new request
// is taken only once the last one has set its result.
// The result register lets the next request in while a result waits; that
// request then holds before its ring read or its first ring write until
// m_axis takes the waiting result.
// Reset clears pointers, caps, phase, counters and sets both lines released;
// ring contents are undefined until written. Configuration writes take
// effect at once and are to be made only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module keyboard_serial_link_device_top #(
	parameter int RING_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: clock_line_in[0], data_line_in[1], usage_code[17:2],
	// is_release[18], is_media[19], zero[23:20]
	input  logic [23:0] s_axis_tdata,
	// tuser: req_type
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: clock_drive[0], data_drive[1], link_phase[4:2], caps_state[5],
	// queue_level[10:6], event_dropped[11], command_done[12],
	// answer_byte[20:13], zero[23:21]
	output logic [23:0] m_axis_tdata
);
	localparam int PW = $clog2(RING_DEPTH);

	logic [7:0] cfg_q [7];
	logic [7:0] ring [RING_DEPTH];
	logic [7:0] rd_data_s2;

	logic [PW-1:0] wptr_q, rptr_q;
	logic          caps_q;
	ksld_pkg::phase_t phase_q;
	logic [7:0] tick_q, rxs_q, txs_q;
	logic [3:0] bit_q;
	logic       clk_lv_q, dat_lv_q;

	// stage s1: key busy or tick waiting for ring read
	logic busy_s1, tick_s1, drop_s1;
	logic clkin_s1, datin_s1;
	ksld_pkg::key_push_t push_s1;
	logic [2:0] pidx_s1;

	logic        out_v_q;
	logic [23:0] out_q;

	ksld_pkg::key_push_t push_c;
	ksld_key_decode u_dec (
		.usage_code(s_axis_tdata[17:2]),
		.is_release(s_axis_tdata[18]),
		.is_media  (s_axis_tdata[19]),
		.caps_q    (caps_q),
		.push      (push_c)
	);

	logic acc, can_out;
	assign can_out       = !out_v_q || m_axis_tready;
	assign s_axis_tready = !busy_s1;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// key push step
	logic       key_act, ring_full, key_last, do_wr;
	logic [7:0] wr_byte;
	assign key_act   = busy_s1 && !tick_s1 && can_out;
	assign ring_full = nxt(wptr_q) == rptr_q;
	assign key_last  = pidx_s1 + 3'd1 >= push_s1.cnt;
	assign do_wr     = key_act && push_s1.cnt != 3'd0 && !ring_full;
	always_comb begin
		unique case (pidx_s1[1:0])
			2'd0: wr_byte = push_s1.b0;
			2'd1: wr_byte = push_s1.b1;
			2'd2: wr_byte = push_s1.b2;
			default: wr_byte = push_s1.b3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_wr) ring[wptr_q] <= wr_byte;
		rd_data_s2 <= ring[rptr_q];
	end

	// link step in tick stage 2
	logic tick_go;
	assign tick_go = busy_s1 && tick_s1 && !pidx_s1[0];

	ksld_pkg::phase_t ph_n;
	logic [7:0] tk_n, rx_n, tx_n, ans_n, tk_inc;
	logic [3:0] bit_n;
	logic cl_n, dl_n, done_n, deq_n;
	assign tk_inc = tick_q + 8'd1;

	always_comb begin
		ph_n = phase_q; tk_n = tick_q; rx_n = rxs_q; tx_n = txs_q;
		bit_n = bit_q; cl_n = clk_lv_q; dl_n = dat_lv_q;
		done_n = 1'b0; deq_n = 1'b0; ans_n = 8'd0;
		unique case (phase_q)
			ksld_pkg::PH_RX_LOW: begin
				cl_n = 1'b0; tk_n = tk_inc;
				if (tk_inc >= cfg_q[ksld_pkg::CFG_RX_LOW]) begin
					tk_n = '0; ph_n = ksld_pkg::PH_RX_HIGH;
				end
			end
			ksld_pkg::PH_RX_HIGH: begin
				cl_n = 1'b1; tk_n = tk_inc;
				if (tk_inc == cfg_q[ksld_pkg::CFG_RX_SAMPLE]) rx_n = {rxs_q[6:0], datin_s1};
				if (tk_inc >= cfg_q[ksld_pkg::CFG_RX_HIGH]) begin
					tk_n = '0; bit_n = bit_q + 4'd1;
					if (bit_q + 4'd1 >= 4'd8) begin
						bit_n = '0; ph_n = ksld_pkg::PH_WAIT_READY; done_n = 1'b1;
						if (rx_n == ksld_pkg::CMD_INQUIRY || rx_n == ksld_pkg::CMD_INSTANT) begin
							if (wptr_q == rptr_q) ans_n = ksld_pkg::ANS_NULL;
							else begin
								ans_n = rd_data_s2; deq_n = 1'b1;
							end
						end else if (rx_n == ksld_pkg::CMD_MODEL) ans_n = ksld_pkg::ANS_MODEL;
						else if (rx_n == ksld_pkg::CMD_TEST) ans_n = ksld_pkg::ANS_ACK;
						else ans_n = ksld_pkg::ANS_NAK;
						tx_n = ans_n;
					end else ph_n = ksld_pkg::PH_RX_LOW;
				end
			end
			ksld_pkg::PH_WAIT_READY: begin
				cl_n = 1'b1; dl_n = 1'b1;
				if (datin_s1) begin
					tk_n = '0; ph_n = ksld_pkg::PH_TX_SETUP;
				end else begin
					tk_n = tk_inc;
					if (tk_inc >= cfg_q[ksld_pkg::CFG_TIMEOUT]) begin
						tk_n = '0; ph_n = ksld_pkg::PH_IDLE;
					end
				end
			end
			ksld_pkg::PH_TX_SETUP: begin
				cl_n = 1'b1; dl_n = txs_q[7]; tk_n = tk_inc;
				if (tk_inc >= cfg_q[ksld_pkg::CFG_TX_SETUP]) begin
					tk_n = '0; ph_n = ksld_pkg::PH_TX_LOW;
				end
			end
			ksld_pkg::PH_TX_LOW: begin
				cl_n = 1'b0; tk_n = tk_inc;
				if (tk_inc >= cfg_q[ksld_pkg::CFG_TX_LOW]) begin
					tk_n = '0; ph_n = ksld_pkg::PH_TX_HIGH;
				end
			end
			ksld_pkg::PH_TX_HIGH: begin
				cl_n = 1'b1; tk_n = tk_inc;
				if (tk_inc >= cfg_q[ksld_pkg::CFG_TX_HIGH]) begin
					tk_n = '0; bit_n = bit_q + 4'd1; tx_n = {txs_q[6:0], 1'b0};
					if (bit_q + 4'd1 >= 4'd8) begin
						bit_n = '0; dl_n = 1'b1; ph_n = ksld_pkg::PH_IDLE;
					end else ph_n = ksld_pkg::PH_TX_SETUP;
				end
			end
			default: begin
				cl_n = 1'b1; dl_n = 1'b1; ph_n = ksld_pkg::PH_IDLE;
				if (clkin_s1 && !datin_s1) begin
					bit_n = '0; rx_n = '0; tk_n = '0; ph_n = ksld_pkg::PH_RX_LOW;
				end
			end
		endcase
	end

	logic [PW-1:0] wptr_n, rptr_n;
	logic [PW:0]   lvl;
	logic [4:0]    lvl5;
	logic          caps_n, key_fin, drop_n, res_set;
	assign wptr_n  = do_wr ? nxt(wptr_q) : wptr_q;
	assign rptr_n  = (tick_go && deq_n) ? nxt(rptr_q) : rptr_q;
	assign caps_n  = caps_q ^ (key_act && push_s1.caps_toggle);
	assign key_fin = key_act && (push_s1.cnt == 3'd0 || key_last);
	assign drop_n  = drop_s1 | (key_act && push_s1.cnt != 3'd0 && ring_full);
	assign res_set = tick_go || key_fin;
	assign lvl     = {1'b0, wptr_n} - {1'b0, rptr_n} + ((wptr_n < rptr_n) ?
		(PW+1)'(RING_DEPTH) : '0);
	assign lvl5    = 5'(lvl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= 8'd11; cfg_q[1] <= 8'd5; cfg_q[2] <= 8'd13; cfg_q[3] <= 8'd2;
			cfg_q[4] <= 8'd10; cfg_q[5] <= 8'd10; cfg_q[6] <= 8'd120;
			wptr_q <= '0; rptr_q <= '0; caps_q <= 1'b0;
			phase_q <= ksld_pkg::PH_IDLE; tick_q <= '0; bit_q <= '0;
			rxs_q <= '0; txs_q <= '0; clk_lv_q <= 1'b1; dat_lv_q <= 1'b1;
			busy_s1 <= 1'b0; tick_s1 <= 1'b0; pidx_s1 <= '0; drop_s1 <= 1'b0;
			out_v_q <= 1'b0; out_q <= '0;
		end else begin
			if (cfg_we && cfg_index <= ksld_pkg::CFG_TIMEOUT) cfg_q[cfg_index] <= cfg_wdata;
			out_v_q <= res_set || (out_v_q && !m_axis_tready);
			wptr_q <= wptr_n; rptr_q <= rptr_n; caps_q <= caps_n;
			if (acc) begin
				busy_s1 <= 1'b1; tick_s1 <= !s_axis_tuser; drop_s1 <= 1'b0;
				pidx_s1 <= {2'b00, !s_axis_tuser};
			end else if (busy_s1 && tick_s1 && pidx_s1[0] && can_out) begin
				// ring read data now valid; evaluate next cycle
				pidx_s1 <= '0;
			end else if (tick_go) begin
				busy_s1 <= 1'b0;
				phase_q <= ph_n; tick_q <= tk_n; bit_q <= bit_n; rxs_q <= rx_n;
				txs_q <= tx_n; clk_lv_q <= cl_n; dat_lv_q <= dl_n;
				out_q <= {3'd0, ans_n, done_n, 1'b0, 5'(lvl5), caps_q, ph_n, dl_n, cl_n};
			end else if (key_act) begin
				drop_s1 <= drop_n;
				pidx_s1 <= pidx_s1 + 3'd1;
				if (key_fin) begin
					busy_s1 <= 1'b0;
					out_q <= {3'd0, 8'd0, 1'b0, drop_n, lvl5, caps_n, phase_q,
						dat_lv_q, clk_lv_q};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			push_s1  <= push_c;
			clkin_s1 <= s_axis_tdata[0];
			datin_s1 <= s_axis_tdata[1];
		end
	end

`ifndef SYNTH
	a_no_dual_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(tick_go && key_act && !tick_s1)) else $error("tick and key overlap");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl <= (PW+1)'(RING_DEPTH - 1)) else $error("ring overfilled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> !busy_s1) else $error("accept while busy");
	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_go && deq_n) |-> (wptr_q != rptr_q)) else $error("dequeue empty");
`endif
endmodule

// File: test/keyboard_serial_link_device_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_serial_link_device_top_tb
// Self-checking bench: drives key events and line ticks on the request
// stream, predicts each result request from an internal link/ring model
// and compares every field in order. Timing registers are reprogrammed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module keyboard_serial_link_device_top_tb;

	localparam int DEPTH = 32;
	localparam int WDOG_LIMIT = 20000;

	typedef struct packed {
		logic        key;
		logic        clk_in;
		logic        dat_in;
		logic [15:0] code;
		logic        rel;
		logic        media;
	} link_req_t;

	// lowest field in the lowest bits
	typedef struct packed {
		logic [7:0] answer;
		logic       done;
		logic       dropped;
		logic [4:0] level;
		logic       caps;
		logic [2:0] ph;
		logic       dat_drv;
		logic       clk_drv;
	} link_res_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [2:0]  cfg_index = '0;
	logic [7:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [23:0] m_axis_tdata;

	keyboard_serial_link_device_top dut (.*);

	initial forever #5 clk = ~clk;

	// predictor state
	logic [7:0] timing [7];
	ksld_pkg::phase_t ph;
	logic [7:0] ticks;
	logic [3:0] bit_idx;
	logic [7:0] rx_sr, tx_sr;
	logic [7:0] ring [DEPTH];
	int         wr_ptr, rd_ptr;
	logic       caps, clk_lvl, dat_lvl, lost;

	link_req_t pending_reqs[$];
	link_res_t expected_res[$];
	int errors = 0, n_results = 0, n_answers = 0, n_drops = 0;
	bit hold_off = 0;
	bit in_acc;
	int in_gap = 0, out_gap = 0;

	function automatic bit count_to(logic [7:0] lim);
		ticks = ticks + 8'd1;
		if (ticks >= lim) begin
			ticks = '0;
			return 1;
		end
		return 0;
	endfunction

	function automatic void ring_push(logic [6:0] scan, logic brk);
		int nx;
		nx = (wr_ptr + 1) % DEPTH;
		if (nx == rd_ptr) begin
			lost = 1'b1;
			return;
		end
		ring[wr_ptr] = {brk | scan[6], scan[5:0], 1'b1};
		wr_ptr = nx;
	endfunction

	function automatic void push_shifted(logic [6:0] scan);
		ring_push(ksld_pkg::SCAN_SHIFT, 1'b0);
		ring_push(scan, 1'b0);
		ring_push(scan, 1'b1);
		ring_push(ksld_pkg::SCAN_SHIFT, 1'b1);
	endfunction

	function automatic logic [7:0] scan_of(logic [7:0] c);
		case (c)
			8'h04: return 8'h00; 8'h05: return 8'h0B; 8'h06: return 8'h08;
			8'h07: return 8'h02; 8'h08: return 8'h0E; 8'h09: return 8'h03;
			8'h0A: return 8'h05; 8'h0B: return 8'h04; 8'h0C: return 8'h22;
			8'h0D: return 8'h26; 8'h0E: return 8'h28; 8'h0F: return 8'h25;
			8'h10: return 8'h2E; 8'h11: return 8'h2D; 8'h12: return 8'h1F;
			8'h13: return 8'h23; 8'h14: return 8'h0C; 8'h15: return 8'h0F;
			8'h16: return 8'h01; 8'h17: return 8'h11; 8'h18: return 8'h20;
			8'h19: return 8'h09; 8'h1A: return 8'h0D; 8'h1B: return 8'h07;
			8'h1C: return 8'h10; 8'h1D: return 8'h06; 8'h1E: return 8'h12;
			8'h1F: return 8'h13; 8'h20: return 8'h14; 8'h21: return 8'h15;
			8'h22: return 8'h17; 8'h23: return 8'h16; 8'h24: return 8'h1A;
			8'h25: return 8'h1C; 8'h26: return 8'h19; 8'h27: return 8'h1D;
			8'h28: return 8'h24; 8'h29: return 8'h35; 8'h2A: return 8'h33;
			8'h2B: return 8'h30; 8'h2C: return 8'h31; 8'h2D: return 8'h1B;
			8'h2E: return 8'h18; 8'h2F: return 8'h21; 8'h30: return 8'h1E;
			8'h31: return 8'h2A; 8'h33: return 8'h29; 8'h34: return 8'h27;
			8'h35: return 8'h32; 8'h36: return 8'h2B; 8'h37: return 8'h2F;
			8'h38: return 8'h2C; 8'h4F: return 8'h42; 8'h50: return 8'h48;
			8'h51: return 8'h4D; 8'h52: return 8'h46; 8'h53: return 8'h47;
			8'h54: return 8'h2C; 8'h56: return 8'h1B; 8'h58: return 8'h24;
			8'h59: return 8'h12; 8'h5A: return 8'h13; 8'h5B: return 8'h14;
			8'h5C: return 8'h15; 8'h5D: return 8'h17; 8'h5E: return 8'h16;
			8'h5F: return 8'h1A; 8'h60: return 8'h1C; 8'h61: return 8'h19;
			8'h62: return 8'h1D; 8'h63: return 8'h2F; 8'h67: return 8'h18;
			8'hE0: return 8'h37; 8'hE1: return 8'h38; 8'hE2: return 8'h3A;
			8'hE3: return 8'h36; 8'hE4: return 8'h37; 8'hE5: return 8'h38;
			8'hE6: return 8'h7C; 8'hE7: return 8'h7B;
			default: return ksld_pkg::NO_SCAN;
		endcase
	endfunction

	function automatic logic [7:0] answer_for(logic [7:0] cmd);
		logic [7:0] v;
		case (cmd)
			ksld_pkg::CMD_INQUIRY, ksld_pkg::CMD_INSTANT: begin
				if (wr_ptr == rd_ptr) return ksld_pkg::ANS_NULL;
				v = ring[rd_ptr];
				rd_ptr = (rd_ptr + 1) % DEPTH;
				return v;
			end
			ksld_pkg::CMD_MODEL: return ksld_pkg::ANS_MODEL;
			ksld_pkg::CMD_TEST: return ksld_pkg::ANS_ACK;
			default: return ksld_pkg::ANS_NAK;
		endcase
	endfunction

	function automatic void apply_key(logic [15:0] code, logic rel, logic media);
		logic [7:0] s;
		if (media || code > 16'd255) return;
		if (code[7:0] == ksld_pkg::KEY_CAPS) begin
			if (!rel) begin
				caps = ~caps;
				ring_push(ksld_pkg::KEY_CAPS[6:0], !caps);
			end
			return;
		end
		if (code[7:0] == ksld_pkg::KEY_KP_STAR) begin
			if (!rel) push_shifted(ksld_pkg::SCAN_EIGHT);
			return;
		end
		if (code[7:0] == ksld_pkg::KEY_KP_PLUS) begin
			if (!rel) push_shifted(ksld_pkg::SCAN_EQUAL);
			return;
		end
		s = scan_of(code[7:0]);
		if (s != ksld_pkg::NO_SCAN) ring_push(s[6:0], rel);
	endfunction

	function automatic bit link_tick(logic ci, logic di, output logic [7:0] ans);
		ans = '0;
		case (ph)
			ksld_pkg::PH_RX_LOW: begin
				clk_lvl = 1'b0;
				if (count_to(timing[ksld_pkg::CFG_RX_LOW])) ph = ksld_pkg::PH_RX_HIGH;
			end
			ksld_pkg::PH_RX_HIGH: begin
				clk_lvl = 1'b1;
				ticks = ticks + 8'd1;
				if (ticks == timing[ksld_pkg::CFG_RX_SAMPLE]) rx_sr = {rx_sr[6:0], di};
				if (ticks >= timing[ksld_pkg::CFG_RX_HIGH]) begin
					ticks = '0;
					bit_idx = bit_idx + 4'd1;
					if (bit_idx >= 4'd8) begin
						tx_sr = answer_for(rx_sr);
						ans = tx_sr;
						bit_idx = '0;
						ph = ksld_pkg::PH_WAIT_READY;
						return 1;
					end
					ph = ksld_pkg::PH_RX_LOW;
				end
			end
			ksld_pkg::PH_WAIT_READY: begin
				clk_lvl = 1'b1;
				dat_lvl = 1'b1;
				if (di) begin
					ticks = '0;
					ph = ksld_pkg::PH_TX_SETUP;
				end else if (count_to(timing[ksld_pkg::CFG_TIMEOUT])) ph = ksld_pkg::PH_IDLE;
			end
			ksld_pkg::PH_TX_SETUP: begin
				clk_lvl = 1'b1;
				dat_lvl = tx_sr[7];
				if (count_to(timing[ksld_pkg::CFG_TX_SETUP])) ph = ksld_pkg::PH_TX_LOW;
			end
			ksld_pkg::PH_TX_LOW: begin
				clk_lvl = 1'b0;
				if (count_to(timing[ksld_pkg::CFG_TX_LOW])) ph = ksld_pkg::PH_TX_HIGH;
			end
			ksld_pkg::PH_TX_HIGH: begin
				clk_lvl = 1'b1;
				if (count_to(timing[ksld_pkg::CFG_TX_HIGH])) begin
					bit_idx = bit_idx + 4'd1;
					tx_sr = {tx_sr[6:0], 1'b0};
					if (bit_idx >= 4'd8) begin
						bit_idx = '0;
						dat_lvl = 1'b1;
						ph = ksld_pkg::PH_IDLE;
					end else ph = ksld_pkg::PH_TX_SETUP;
				end
			end
			default: begin
				clk_lvl = 1'b1;
				dat_lvl = 1'b1;
				ph = ksld_pkg::PH_IDLE;
				if (ci && !di) begin
					bit_idx = '0;
					rx_sr = '0;
					ticks = '0;
					ph = ksld_pkg::PH_RX_LOW;
				end
			end
		endcase
		return 0;
	endfunction

	function automatic link_res_t predict_step(link_req_t r);
		link_res_t e;
		logic [7:0] ans;
		bit done;
		lost = 1'b0;
		done = 0;
		ans = '0;
		if (r.key) apply_key(r.code, r.rel, r.media);
		else done = link_tick(r.clk_in, r.dat_in, ans);
		e.clk_drv = clk_lvl;
		e.dat_drv = dat_lvl;
		e.ph = ph;
		e.caps = caps;
		e.level = 5'((wr_ptr + DEPTH - rd_ptr) % DEPTH);
		e.dropped = lost;
		e.done = done;
		e.answer = done ? ans : 8'h00;
		return e;
	endfunction

	// driver
	always @(negedge clk) begin
		link_req_t r;
		if (arst_n) begin
			if (in_acc) begin
				r = pending_reqs.pop_front();
				expected_res.push_back(predict_step(r));
			end
			if (!s_axis_tvalid || in_acc) begin
				if (in_gap > 0) begin
					in_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0 && !hold_off) begin
					r = pending_reqs[0];
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= r.key;
					s_axis_tdata <= {4'b0, r.media, r.rel, r.code, r.dat_in, r.clk_in};
					if ($urandom_range(0, 5) == 0)
						in_gap = ($urandom_range(0, 19) == 0) ?
							$urandom_range(10, 40) : $urandom_range(1, 3);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(0, 4) == 0)
					out_gap = ($urandom_range(0, 19) == 0) ?
						$urandom_range(10, 40) : $urandom_range(1, 3);
			end
		end
	end

	// monitor
	int idle_cycles = 0;
	always @(posedge clk) begin
		link_res_t a, e;
		in_acc = s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			idle_cycles++;
			if (in_acc) idle_cycles = 0;
			if (m_axis_tvalid && m_axis_tready) begin
				idle_cycles = 0;
				a = link_res_t'(m_axis_tdata[20:0]);
				n_results++;
				if (expected_res.size() == 0) begin
					$display("%0t: unexpected result %h", $time, a);
					errors++;
				end else begin
					e = expected_res.pop_front();
					if (a.done && a.answer != 0) n_answers++;
					if (a.dropped) n_drops++;
					if (a !== e) begin
						$display("%0t: mismatch exp %h act %h", $time, e, a);
						errors++;
					end
				end
			end
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("%0t: watchdog timeout", $time);
				$display("keyboard_serial_link_device_top_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic add_tick(logic c, logic d);
		link_req_t r;
		r = '0;
		r.clk_in = c;
		r.dat_in = d;
		pending_reqs.push_back(r);
	endtask

	task automatic add_key(logic [15:0] code, logic rel, logic media);
		link_req_t r;
		r = '0;
		r.key = 1'b1;
		r.code = code;
		r.rel = rel;
		r.media = media;
		pending_reqs.push_back(r);
	endtask

	// host clocking a command byte in, then releasing data and idling the reply
	task automatic add_command(logic [7:0] cmd, int slack);
		int ev;
		add_tick(1'b1, 1'b0);
		for (int b = 7; b >= 0; b--)
			for (int k = 0; k < slack; k++) begin
				add_tick(1'($urandom_range(0, 1)), cmd[b]);
				ev = $urandom_range(0, 15);
				if (ev == 0)
					add_key(16'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
			end
		for (int k = 0; k < 40; k++) add_tick(1'b1, $urandom_range(0, 7) != 0);
	endtask

	task automatic wait_drain(int settle);
		hold_off = 0;
		while (pending_reqs.size() > 0 || expected_res.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic set_timing(logic [2:0] idx, logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		timing[idx] = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int n_items);
		int cnt;
		int slack;
		logic [7:0] cmds [6];
		cmds = '{ksld_pkg::CMD_INQUIRY, ksld_pkg::CMD_INSTANT, ksld_pkg::CMD_MODEL,
			ksld_pkg::CMD_TEST, 8'hFF, 8'h00};
		cnt = 0;
		while (cnt < n_items) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin
					slack = $urandom_range(2, 8);
					add_command($urandom_range(0, 3) == 0 ? 8'($urandom) :
						cmds[$urandom_range(0, 5)], slack);
					cnt += 41 + 8 * slack;
				end
				3: begin
					add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					cnt++;
				end
				4: begin
					add_key(16'($urandom), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					cnt++;
				end
				default: begin
					add_key(16'($urandom_range(0, 3) == 0 ?
						($urandom_range(0, 1) ? ksld_pkg::KEY_KP_STAR : ksld_pkg::KEY_KP_PLUS) :
						$urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
					cnt++;
				end
			endcase
		end
		wait_drain(10);
	endtask

	initial begin
		for (int i = 0; i < 7; i++) timing[i] = '0;
		timing[ksld_pkg::CFG_RX_LOW] = 8'd11; timing[ksld_pkg::CFG_RX_SAMPLE] = 8'd5;
		timing[ksld_pkg::CFG_RX_HIGH] = 8'd13; timing[ksld_pkg::CFG_TX_SETUP] = 8'd2;
		timing[ksld_pkg::CFG_TX_LOW] = 8'd10; timing[ksld_pkg::CFG_TX_HIGH] = 8'd10;
		timing[ksld_pkg::CFG_TIMEOUT] = 8'd120;
		ph = ksld_pkg::PH_IDLE; ticks = '0; bit_idx = '0; rx_sr = '0; tx_sr = '0;
		wr_ptr = 0; rd_ptr = 0; caps = 1'b0; clk_lvl = 1'b1; dat_lvl = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		hold_off = 1;

		// directed: minimal timing, extremes, special keys, every command
		set_timing(ksld_pkg::CFG_RX_LOW, 8'd1); set_timing(ksld_pkg::CFG_RX_SAMPLE, 8'd1);
		set_timing(ksld_pkg::CFG_RX_HIGH, 8'd1); set_timing(ksld_pkg::CFG_TX_SETUP, 8'd1);
		set_timing(ksld_pkg::CFG_TX_LOW, 8'd1); set_timing(ksld_pkg::CFG_TX_HIGH, 8'd1);
		set_timing(ksld_pkg::CFG_TIMEOUT, 8'd1);
		// empty ring answers null
		add_command(ksld_pkg::CMD_INQUIRY, 2);
		add_key(16'hFFFF, 1'b1, 1'b1); add_key(16'h0100, 1'b0, 1'b0);
		add_key(16'h0004, 1'b0, 1'b1);
		add_key(16'(ksld_pkg::KEY_CAPS), 1'b0, 1'b0);
		add_key(16'(ksld_pkg::KEY_CAPS), 1'b1, 1'b0);
		add_key(16'(ksld_pkg::KEY_CAPS), 1'b0, 1'b0);
		add_key(16'(ksld_pkg::KEY_KP_STAR), 1'b0, 1'b0);
		add_key(16'(ksld_pkg::KEY_KP_STAR), 1'b1, 1'b0);
		add_key(16'(ksld_pkg::KEY_KP_PLUS), 1'b0, 1'b0);
		add_key(16'h00E7, 1'b1, 1'b0); add_key(16'h00FF, 1'b0, 1'b0);
		add_key(16'h0000, 1'b0, 1'b0);
		add_command(ksld_pkg::CMD_INQUIRY, 2); add_command(ksld_pkg::CMD_INSTANT, 2);
		add_command(ksld_pkg::CMD_MODEL, 2); add_command(ksld_pkg::CMD_TEST, 2);
		add_command(8'hA5, 2);
		wait_drain(10);
		// fill the ring past full
		for (int i = 0; i < 8; i++) add_key(16'(ksld_pkg::KEY_KP_PLUS), 1'b0, 1'b0);
		wait_drain(10);
		for (int i = 0; i < 4; i++) add_command(ksld_pkg::CMD_INQUIRY, 2);
		wait_drain(10);

		// sample tick beyond the high phase, then maximal values
		set_timing(ksld_pkg::CFG_RX_SAMPLE, 8'd9); set_timing(ksld_pkg::CFG_RX_HIGH, 8'd3);
		run_phase(250);
		set_timing(ksld_pkg::CFG_RX_LOW, 8'd255); set_timing(ksld_pkg::CFG_RX_SAMPLE, 8'd255);
		set_timing(ksld_pkg::CFG_RX_HIGH, 8'd255); set_timing(ksld_pkg::CFG_TX_SETUP, 8'd255);
		set_timing(ksld_pkg::CFG_TX_LOW, 8'd255); set_timing(ksld_pkg::CFG_TX_HIGH, 8'd255);
		set_timing(ksld_pkg::CFG_TIMEOUT, 8'd255);
		run_phase(100);
		set_timing(ksld_pkg::CFG_RX_LOW, 8'd3); set_timing(ksld_pkg::CFG_RX_SAMPLE, 8'd2);
		set_timing(ksld_pkg::CFG_RX_HIGH, 8'd4); set_timing(ksld_pkg::CFG_TX_SETUP, 8'd2);
		set_timing(ksld_pkg::CFG_TX_LOW, 8'd3); set_timing(ksld_pkg::CFG_TX_HIGH, 8'd2);
		set_timing(ksld_pkg::CFG_TIMEOUT, 8'd20);
		run_phase(400);
		set_timing(ksld_pkg::CFG_RX_SAMPLE, 8'd1); set_timing(ksld_pkg::CFG_RX_HIGH, 8'd2);
		set_timing(ksld_pkg::CFG_TIMEOUT, 8'd5);
		run_phase(350);
		repeat (20) @(posedge clk);
		if (expected_res.size() > 0) begin
			$display("%0t: %0d results never arrived", $time, expected_res.size());
			errors++;
		end
		$display("covered %0d results, %0d command answers, %0d drop events",
			n_results, n_answers, n_drops);
		if (errors == 0) begin
			$display("keyboard_serial_link_device_top_tb: PASS");
		end else begin
			$display("keyboard_serial_link_device_top_tb: FAIL");
		end
		$finish;
	end

endmodule
